[rtl/core/lfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfd_pkg: shared types and constants
// Frame record layout, protocol constants and the bar pattern function for
// the serial frame to display write converter.
// ----------------------------------------------------------------------------
package lfd_pkg;

    // frame layout
    localparam int FRAME_LEN    = 6;
    localparam int STORED_BYTES = FRAME_LEN - 1;
    localparam int N_DIGITS     = 3;
    localparam int BAR_BYTE     = 3;
    localparam int BRIGHT_BYTE  = 4;

    // terminators
    localparam logic [7:0] TERM_CR = 8'd13;
    localparam logic [7:0] TERM_LF = 8'd10;

    // display register addresses
    localparam logic [3:0] ADDR_DIGIT0     = 4'd1;
    localparam logic [3:0] ADDR_BAR0       = 4'd4;
    localparam logic [3:0] ADDR_BRIGHTNESS = 4'h A;

    // configuration
    localparam logic [4:0] BAR_LIMIT_RESET = 5'd20;

    // frame queue depth
    localparam int Q_DEPTH = 2;

    // one good frame, ready for the write sequencer
    typedef struct packed {
        logic [N_DIGITS-1:0][7:0] digits;
        logic [4:0]               bar_count;   // already clamped
        logic [3:0]               bright;
    } t_frame;

    // thermometer pattern for one bar group, MSB first
    function automatic logic [7:0] bar_bits(input logic [4:0] lit_total,
                                            input logic [1:0] group);
        logic [5:0] base;
        logic [5:0] lit;
        logic [3:0] n;
        base = {1'b0, group, 3'b000};
        lit  = {1'b0, lit_total} - base;
        if ({1'b0, lit_total} <= base) begin
            n = 4'd0;
        end else if (lit > 6'd8) begin
            n = 4'd8;
        end else begin
            n = lit[3:0];
        end
        return ~(8'hFF >> n);
    endfunction

endpackage

[rtl/core/lfd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfd_front: frame assembler
// Collects received bytes, checks the terminator and pushes good frames,
// with the bar count clamped, into the frame queue.
// ----------------------------------------------------------------------------
module lfd_front import lfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    input  logic [4:0] i_bar_limit,
    output logic       o_push,
    output t_frame     o_frame,
    input  logic       i_q_ready
);

    logic [2:0] r_byte_count;
    logic [2:0] n_byte_count;
    logic [7:0] r_frame_bytes [STORED_BYTES];

    logic at_term;
    logic term_ok;
    logic accept;

    assign at_term = (r_byte_count >= 3'(STORED_BYTES));
    assign term_ok = (i_rx_byte == TERM_CR) || (i_rx_byte == TERM_LF);
    // data bytes never need the queue; only a terminator does
    assign o_ready = !at_term || i_q_ready;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && at_term && term_ok;

    // byte counter
    always_comb begin
        n_byte_count = r_byte_count;
        if (accept) begin
            if (at_term) begin
                n_byte_count = 3'd0;
            end else begin
                n_byte_count = r_byte_count + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= 3'd0;
        end else begin
            r_byte_count <= n_byte_count;
        end
    end

    // frame byte store, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept && !at_term) begin
            r_frame_bytes[r_byte_count] <= i_rx_byte;
        end
    end

    // frame record, bar count clamped to the limit
    always_comb begin
        for (int k = 0; k < N_DIGITS; k++) begin
            o_frame.digits[k] = r_frame_bytes[k];
        end
        if (r_frame_bytes[BAR_BYTE] > {3'b000, i_bar_limit}) begin
            o_frame.bar_count = i_bar_limit;
        end else begin
            o_frame.bar_count = r_frame_bytes[BAR_BYTE][4:0];
        end
        o_frame.bright = r_frame_bytes[BRIGHT_BYTE][3:0];
    end

endmodule

[rtl/core/lfd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfd_queue: frame queue
// Short FIFO of frame records between the assembler and the sequencer.
// ----------------------------------------------------------------------------
module lfd_queue import lfd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_frame i_frame,
    output logic   o_ready,
    output logic   o_valid,
    output t_frame o_frame,
    input  logic   i_pop
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_frame         r_mem [Q_DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic [PW-1:0]  n_wr_ptr;
    logic [PW-1:0]  n_rd_ptr;
    logic [CW-1:0]  n_count;

    assign o_ready = (r_count != CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_frame = r_mem[r_rd_ptr];

    // pointer and fill update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

endmodule

[rtl/core/lfd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfd_back: write sequencer
// Turns each queued frame into its burst of display register writes, one
// write per cycle while i_ready allows, into a registered output stage.
// ----------------------------------------------------------------------------
module lfd_back import lfd_pkg::*; #(
    parameter int BAR_GROUPS = 3
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_frame     i_frame,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_reg_address,
    output logic [7:0] o_reg_data,
    output logic       o_last
);

    localparam int N_WRITES = N_DIGITS + BAR_GROUPS + 1;
    localparam int IW       = $clog2(N_WRITES);

    logic [IW-1:0] r_idx;
    logic [IW-1:0] n_idx;
    logic          r_valid;
    logic [3:0]    r_addr;
    logic [7:0]    r_data;
    logic          r_last;

    logic          load;
    logic          is_last;
    logic [IW-1:0] bar_idx;
    logic [3:0]    w_addr;
    logic [7:0]    w_data;

    assign load    = !r_valid || i_ready;
    assign is_last = (r_idx == IW'(N_WRITES - 1));
    assign o_pop   = load && i_q_valid && is_last;
    assign bar_idx = r_idx - IW'(N_DIGITS);

    // select the write for the current step
    always_comb begin
        if (r_idx < IW'(N_DIGITS)) begin
            w_addr = ADDR_DIGIT0 + 4'(r_idx);
            w_data = i_frame.digits[r_idx[1:0]];
        end else if (!is_last) begin
            w_addr = ADDR_BAR0 + 4'(bar_idx);
            w_data = bar_bits(i_frame.bar_count, 2'(bar_idx));
        end else begin
            w_addr = ADDR_BRIGHTNESS;
            w_data = {4'h0, i_frame.bright};
        end
    end

    // step counter
    always_comb begin
        n_idx = r_idx;
        if (load && i_q_valid) begin
            n_idx = is_last ? '0 : r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= i_q_valid;
            end
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (load && i_q_valid) begin
            r_addr <= w_addr;
            r_data <= w_data;
            r_last <= is_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_reg_address = r_addr;
    assign o_reg_data    = r_data;
    assign o_last        = r_last;

endmodule

[rtl/core/led_frame_to_display_writes_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_frame_to_display_writes_top: serial frame to display writes
// Gathers 6-byte serial frames and, for each frame with a CR or LF
// terminator, issues the display register writes for digits, bar and
// brightness.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------
//  rx in     | i_valid / o_ready  | i_rx_byte
//  writes out| o_valid / i_ready  | o_reg_address, o_reg_data, o_last
//  config    | i_bar_limit_we     | i_bar_limit_wdata
//
// Input bytes are taken one per cycle unless a terminator waits for queue room;
// a good frame yields BAR_GROUPS+4 writes, one per cycle while i_ready is high.
// With more writes than bytes per frame, the sequencer sets the sustained rate.
// Reset is synchronous, active low; bar_limit resets to 20.
// A terminator byte stalls only while the two-entry frame queue is full;
// the output register lets the sequencer keep loading while a write is taken.
// ----------------------------------------------------------------------------
module led_frame_to_display_writes_top import lfd_pkg::*; #(
    parameter int BAR_GROUPS = 3
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_reg_address,
    output logic [7:0] o_reg_data,
    output logic       o_last,
    input  logic       i_bar_limit_we,
    input  logic [4:0] i_bar_limit_wdata
);

    logic [4:0] r_bar_limit;
    logic       q_push;
    logic       q_ready;
    logic       q_valid;
    logic       q_pop;
    t_frame     push_frame;
    t_frame     head_frame;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bar_limit <= BAR_LIMIT_RESET;
        end else if (i_bar_limit_we) begin
            r_bar_limit <= i_bar_limit_wdata;
        end
    end

    lfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_rx_byte   (i_rx_byte),
        .i_bar_limit (r_bar_limit),
        .o_push      (q_push),
        .o_frame     (push_frame),
        .i_q_ready   (q_ready)
    );

    lfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_frame (push_frame),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_frame (head_frame),
        .i_pop   (q_pop)
    );

    lfd_back #(
        .BAR_GROUPS (BAR_GROUPS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_frame       (head_frame),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_reg_address (o_reg_address),
        .o_reg_data    (o_reg_data),
        .o_last        (o_last)
    );

    // the final write of a burst is always the brightness write
    a_last_is_bright: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_reg_address == ADDR_BRIGHTNESS)
        else $error("last write not at brightness address");

    a_bright_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_reg_address == ADDR_BRIGHTNESS) |-> o_last)
        else $error("brightness write without last flag");

    // a frame is never pushed into a full queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> q_ready)
        else $error("frame pushed into full queue");

    // no write is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

[dv/led_frame_to_display_writes_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_frame_to_display_writes_top_test: frame to display write checks
// Drives 6-byte serial frames into the converter with random gaps on both
// channels, predicts the display register writes of each good frame and
// compares every write, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module led_frame_to_display_writes_top_test;
    import lfd_pkg::*;

    localparam int BAR_GROUPS    = 3;
    localparam int CLK_HALF      = 10;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_PRINTED   = 100;

    // one display register write
    typedef struct packed {
        logic [3:0] addr;
        logic [7:0] data;
        logic       last;
    } t_disp_write;

    logic       i_clk             = 1'b0;
    logic       i_rst_n           = 1'b0;
    logic       i_valid           = 1'b0;
    logic [7:0] i_rx_byte         = 8'd0;
    logic       i_ready           = 1'b0;
    logic       i_bar_limit_we    = 1'b0;
    logic [4:0] i_bar_limit_wdata = 5'd0;
    logic       o_ready;
    logic       o_valid;
    logic [3:0] o_reg_address;
    logic [7:0] o_reg_data;
    logic       o_last;

    // predictor state
    logic [7:0]  frame_store [STORED_BYTES];
    int          frame_pos = 0;
    logic [4:0]  bar_limit_model = BAR_LIMIT_RESET;
    t_disp_write pending_writes [$];

    int error_count  = 0;
    int cycle_count  = 0;
    bit quiet_mode   = 1'b0;
    int hold_request = 0;
    int hold_left    = 0;
    int stall_left   = 0;

    led_frame_to_display_writes_top #(
        .BAR_GROUPS(BAR_GROUPS)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_reg_address    (o_reg_address),
        .o_reg_data       (o_reg_data),
        .o_last           (o_last),
        .i_bar_limit_we   (i_bar_limit_we),
        .i_bar_limit_wdata(i_bar_limit_wdata)
    );

    // clock
    always #CLK_HALF i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("led_frame_to_display_writes_top: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int expected_v, input int got_v);
        if (error_count < MAX_PRINTED) begin
            $display("ERROR at %0t: %s: expected %0h, got %0h", $realtime, what,
                     expected_v, got_v);
        end
        error_count++;
    endtask

    // predict the writes caused by one accepted byte
    task automatic predict_rx_byte(input logic [7:0] b);
        t_disp_write w;
        int          lit;
        int          n;
        int          g;
        int          d;
        int          i;
        logic [7:0]  pat;
        if (frame_pos < FRAME_LEN - 1) begin
            frame_store[3'(frame_pos)] = b;
            frame_pos++;
        end else begin
            frame_pos = 0;
            if (b == TERM_CR || b == TERM_LF) begin
                for (d = 0; d < N_DIGITS; d++) begin
                    w.addr = 4'(ADDR_DIGIT0 + d);
                    w.data = frame_store[3'(d)];
                    w.last = 1'b0;
                    pending_writes.push_back(w);
                end
                // clamp the count, then fill groups MSB first
                lit = int'(frame_store[BAR_BYTE]);
                if (lit > int'(bar_limit_model)) lit = int'(bar_limit_model);
                for (g = 0; g < BAR_GROUPS; g++) begin
                    n = lit - g * 8;
                    if (n < 0) n = 0;
                    if (n > 8) n = 8;
                    pat = 8'h00;
                    for (i = 0; i < n; i++) pat[3'(7 - i)] = 1'b1;
                    w.addr = 4'(ADDR_BAR0 + g);
                    w.data = pat;
                    w.last = 1'b0;
                    pending_writes.push_back(w);
                end
                w.addr = ADDR_BRIGHTNESS;
                w.data = {4'h0, frame_store[BRIGHT_BYTE][3:0]};
                w.last = 1'b1;
                pending_writes.push_back(w);
            end
        end
    endtask

    // write checker
    always @(posedge i_clk) begin : check_writes
        t_disp_write expected_w;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_writes.size() == 0) begin
                report_mismatch("write with none expected, address", 0,
                                int'(o_reg_address));
            end else begin
                expected_w = pending_writes.pop_front();
                if (o_reg_address !== expected_w.addr)
                    report_mismatch("reg_address", int'(expected_w.addr),
                                    int'(o_reg_address));
                if (o_reg_data !== expected_w.data)
                    report_mismatch("reg_data", int'(expected_w.data), int'(o_reg_data));
                if (o_last !== expected_w.last)
                    report_mismatch("last", int'(expected_w.last), int'(o_last));
            end
        end
    end

    // write receiver: random stalls, plus long holds on request
    always @(negedge i_clk) begin : drive_ready
        int r;
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (quiet_mode) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                i_ready <= 1'b1;
            end else if (r < 95) begin
                stall_left = $urandom_range(0, 3);
                i_ready <= 1'b0;
            end else begin
                stall_left = $urandom_range(10, 40);
                i_ready <= 1'b0;
            end
        end
    end

    // sender gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (quiet_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 80) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // offer one byte and wait until it is taken
    task automatic send_rx_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk) i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        predict_rx_byte(b);
    endtask

    task automatic send_frame(input logic [7:0] d0, input logic [7:0] d1,
                              input logic [7:0] d2, input logic [7:0] bar_count,
                              input logic [7:0] bright, input logic [7:0] term);
        send_rx_byte(d0);
        send_rx_byte(d1);
        send_rx_byte(d2);
        send_rx_byte(bar_count);
        send_rx_byte(bright);
        send_rx_byte(term);
    endtask

    // mostly good frames with random content, some with a bad terminator
    task automatic send_random_frame();
        logic [7:0] bar_count;
        logic [7:0] term;
        int         r;
        bar_count = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 30))
                                                : 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 43)      term = TERM_CR;
        else if (r < 86) term = TERM_LF;
        else             term = 8'($urandom_range(0, 255));
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), bar_count,
                   8'($urandom_range(0, 255)), term);
    endtask

    // stop offering and wait for every predicted write, then let it settle
    task automatic wait_writes_drained();
        @(negedge i_clk) i_valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_bar_limit(input logic [4:0] value);
        @(negedge i_clk);
        i_bar_limit_we    <= 1'b1;
        i_bar_limit_wdata <= value;
        @(posedge i_clk);
        bar_limit_model = value;
        @(negedge i_clk) i_bar_limit_we <= 1'b0;
    endtask

    // digit extremes, both terminators, a dropped frame, brightness high nibble
    task automatic test_directed_frames();
        send_frame(8'h00, 8'hFF, 8'hA5, 8'hFF, 8'hFF, TERM_CR);
        send_frame(8'hFF, 8'h00, 8'h5A, 8'h00, 8'h0F, TERM_LF);
        send_frame(8'h12, 8'h34, 8'h56, 8'h10, 8'h07, 8'h0C);
        send_frame(8'h81, 8'h7E, 8'h3C, 8'h09, 8'hF0, TERM_LF);
        wait_writes_drained();
    endtask

    // dark bar, full bar with partial groups, and a mid limit
    task automatic test_bar_limit_extremes();
        write_bar_limit(5'd0);
        send_frame(8'h01, 8'h02, 8'h03, 8'hFF, 8'h05, TERM_CR);
        send_frame(8'hC0, 8'h0C, 8'h33, 8'h01, 8'hAA, TERM_LF);
        wait_writes_drained();
        write_bar_limit(5'd24);
        send_frame(8'h11, 8'h22, 8'h33, 8'd24, 8'h55, TERM_CR);
        send_frame(8'h44, 8'h55, 8'h66, 8'd23, 8'h3B, TERM_LF);
        send_frame(8'h77, 8'h88, 8'h99, 8'hFF, 8'hC4, TERM_CR);
        send_frame(8'hAB, 8'hCD, 8'hEF, 8'd16, 8'h8D, 8'h8D);
        wait_writes_drained();
        write_bar_limit(5'd7);
        send_frame(8'h10, 8'h20, 8'h30, 8'd9, 8'h66, TERM_LF);
        wait_writes_drained();
    endtask

    task automatic test_random_frames();
        int phase;
        int f;
        for (phase = 0; phase < 2; phase++) begin
            write_bar_limit(5'($urandom_range(0, 24)));
            for (f = 0; f < 2; f++) send_random_frame();
            wait_writes_drained();
        end
    endtask

    // receiver holds off while frames keep coming, so the input stalls
    task automatic test_backpressure_fill();
        int f;
        write_bar_limit(5'($urandom_range(0, 24)));
        quiet_mode   = 1'b1;
        hold_request = 80;
        for (f = 0; f < 3; f++) begin
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 30)),
                       8'($urandom_range(0, 255)),
                       ($urandom_range(0, 1) == 0) ? TERM_CR : TERM_LF);
        end
        wait_writes_drained();
        quiet_mode = 1'b0;
    endtask

    // full rate on both sides
    task automatic test_no_idle_burst();
        int f;
        write_bar_limit(5'd24);
        quiet_mode = 1'b1;
        for (f = 0; f < 2; f++) send_random_frame();
        wait_writes_drained();
        quiet_mode = 1'b0;
    endtask

    // main sequence
    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_frames();
        test_bar_limit_extremes();
        test_random_frames();
        test_backpressure_fill();
        test_no_idle_burst();

        wait_writes_drained();
        if (pending_writes.size() != 0)
            report_mismatch("writes never issued", 0, pending_writes.size());
        if (error_count == 0) begin
            $display("led_frame_to_display_writes_top: match");
        end else begin
            $display("led_frame_to_display_writes_top: mismatch");
        end
        $finish;
    end

endmodule

[led_frame_to_display_writes_top.f]
rtl/core/lfd_pkg.sv
rtl/core/lfd_front.sv
rtl/core/lfd_queue.sv
rtl/core/lfd_back.sv
rtl/core/led_frame_to_display_writes_top.sv
dv/led_frame_to_display_writes_top_test.sv
